// ----- src/dmc_pkg.sv -----
`default_nettype none

package dmc_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_PROBE,
		ST_DECIDE,
		ST_POP,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_RUN,
		PH_DONE
	} phase_t;

	localparam logic [2:0] EV_BEGIN   = 3'd0;
	localparam logic [2:0] EV_MOVE    = 3'd1;
	localparam logic [2:0] EV_BACK    = 3'd2;
	localparam logic [2:0] EV_FINISH  = 3'd3;
	localparam logic [2:0] EV_IGNORED = 3'd4;

	localparam logic [1:0] WALL_NONE   = 2'd0;
	localparam logic [1:0] WALL_RIGHT  = 2'd1;
	localparam logic [1:0] WALL_BOTTOM = 2'd2;

	localparam logic [1:0] DIR_UP    = 2'd0;
	localparam logic [1:0] DIR_DOWN  = 2'd1;
	localparam logic [1:0] DIR_LEFT  = 2'd2;
	localparam logic [1:0] DIR_RIGHT = 2'd3;

	localparam logic ACT_BEGIN = 1'b0;

	localparam int CfgW = 6;
	localparam logic [CfgW-1:0] CFG_RESET = 6'd16;
	localparam logic [2:0] ADDR_COLS = 3'd0;
	localparam logic [2:0] ADDR_ROWS = 3'd4;

	typedef logic [8:0] dim_t;

	typedef struct packed {
		dim_t cols;
		dim_t rows;
	} dims_t;

	// residue of an 8-bit value by three from its base-4 digit sum
	function automatic logic [1:0] mod3_8(input logic [7:0] v);
		logic [3:0] s;
		s = 4'(v[1:0]) + 4'(v[3:2]) + 4'(v[5:4]) + 4'(v[7:6]);
		case (s) inside
			4'd0, 4'd3, 4'd6, 4'd9, 4'd12: return 2'd0;
			4'd1, 4'd4, 4'd7, 4'd10:       return 2'd1;
			default:                       return 2'd2;
		endcase
	endfunction

	// direction of the k-th free neighbour in up, down, left, right order
	function automatic logic [1:0] pick_dir(input logic [3:0] free, input logic [1:0] k);
		logic [1:0] d;
		logic [2:0] seen;
		d = DIR_UP;
		seen = 3'd0;
		for (int i = 0; i < 4; i++) begin
			if (free[i]) begin
				if (seen == 3'(k)) begin
					d = 2'(i);
				end
				seen = seen + 3'd1;
			end
		end
		return d;
	endfunction

endpackage

`default_nettype wire

// ----- src/dmc_cfg_regs.sv -----
`default_nettype none

module dmc_cfg_regs #(
	parameter int MAX_COLS = 32,
	parameter int MAX_ROWS = 32
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          psel,
	input  wire logic          penable,
	input  wire logic          pwrite,
	input  wire logic [2:0]    paddr,
	input  wire logic [31:0]   pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output dmc_pkg::dims_t     dims
);

	localparam dmc_pkg::dim_t MaxColsW = 9'(MAX_COLS);
	localparam dmc_pkg::dim_t MaxRowsW = 9'(MAX_ROWS);

	logic [dmc_pkg::CfgW-1:0] cols_q;
	logic [dmc_pkg::CfgW-1:0] rows_q;
	logic                     wr_en;
	dmc_pkg::dim_t            cols_raw;
	dmc_pkg::dim_t            rows_raw;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= dmc_pkg::CFG_RESET;
			rows_q <= dmc_pkg::CFG_RESET;
		end else if (wr_en) begin
			if (paddr[2] == dmc_pkg::ADDR_ROWS[2]) begin
				rows_q <= pwdata[dmc_pkg::CfgW-1:0];
			end else begin
				cols_q <= pwdata[dmc_pkg::CfgW-1:0];
			end
		end
	end

	always_comb begin
		if (paddr[2] == dmc_pkg::ADDR_COLS[2]) begin
			prdata = 32'(cols_q);
		end else begin
			prdata = 32'(rows_q);
		end
	end

	// zero acts as one, above the maximum acts as the maximum
	assign cols_raw = 9'(cols_q);
	assign rows_raw = 9'(rows_q);

	always_comb begin
		if (cols_q == '0) begin
			dims.cols = 9'd1;
		end else if (cols_raw > MaxColsW) begin
			dims.cols = MaxColsW;
		end else begin
			dims.cols = cols_raw;
		end
		if (rows_q == '0) begin
			dims.rows = 9'd1;
		end else if (rows_raw > MaxRowsW) begin
			dims.rows = MaxRowsW;
		end else begin
			dims.rows = rows_raw;
		end
	end

endmodule

`default_nettype wire

// ----- src/dfs_maze_carver_unit.sv -----
`default_nettype none

// Maze carver by depth-first search with an explicit stack, one transaction in and one
// result transaction out per item, one item at a time. A begin item sweeps all
// 2^(clog2(MAX_COLS)+clog2(MAX_ROWS)) entries of the visited bitmap (1024 by default),
// one entry per cycle, before its result is emitted; the bitmap is uninitialized
// after reset, so steps before the first begin are reported as ignored. A step reads the
// four neighbours through the single bitmap read port, one per cycle, then decides and
// carves; a backtrack passes through an extra pop state, which waits for the stack
// read, and an ignored step goes straight to emitting its result. The input is ready
// again once the result sits in the output register, unless a stalled earlier result
// still holds that register. Grid size is set through the APB registers grid_cols
// (0x0) and grid_rows (0x4) and must only change while the block is idle.
module dfs_maze_carver_unit #(
	parameter int MAX_COLS = 32,
	parameter int MAX_ROWS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // random_value
	input  wire logic        s_tuser,   // action
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata,   // cur_col, cur_row, wall_col, wall_row, wall_kind, done_res
	output logic [2:0]       m_tuser,   // event_res
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	localparam int CW     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int RW     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int AW     = CW + RW;
	localparam int VDEPTH = 1 << AW;
	localparam int SDEPTH = MAX_COLS * MAX_ROWS;
	localparam int SAW    = (SDEPTH > 1) ? $clog2(SDEPTH) : 1;
	localparam int SPW    = $clog2(SDEPTH + 1);

	dmc_pkg::dims_t   dims;
	dmc_pkg::state_t  state_q, state_d;
	dmc_pkg::phase_t  phase_q;

	logic [CW-1:0]    col_q;
	logic [RW-1:0]    row_q;
	logic [SPW-1:0]   sp_q;
	logic [2:0]       probe_q;
	logic [AW-1:0]    clr_q;
	logic [3:0]       free_q;
	logic [7:0]       rnd_q;
	logic [2:0]       ev_q;
	logic [4:0]       wcol_q;
	logic [4:0]       wrow_q;
	logic [1:0]       wkind_q;
	logic             m_tvalid_q;
	logic [23:0]      m_tdata_q;
	logic [2:0]       m_tuser_q;

	logic             vis_mem [0:VDEPTH-1];
	logic             vis_rd_q;
	logic [AW-1:0]    stk_mem [0:SDEPTH-1];
	logic [AW-1:0]    stk_rd_q;

	logic             accept;
	logic             emit_ok;
	logic [3:0]       inr;
	logic [2:0]       cand_n;
	logic [1:0]       cand_k;
	logic [1:0]       pick;
	logic [1:0]       nb_dir;
	logic [CW-1:0]    nb_col;
	logic [RW-1:0]    nb_row;
	logic [1:0]       cap_idx;
	logic             clr_last;
	logic             vis_we;
	logic [AW-1:0]    vis_waddr;
	logic             vis_wdata;
	logic             stk_we;
	logic [SAW-1:0]   stk_raddr;
	logic             done_flag;

	dmc_cfg_regs #(
		.MAX_COLS (MAX_COLS),
		.MAX_ROWS (MAX_ROWS)
	) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.dims    (dims)
	);

	// neighbour range checks against the live grid size
	assign inr[dmc_pkg::DIR_UP]    = (row_q != '0);
	assign inr[dmc_pkg::DIR_DOWN]  = ((9'(row_q) + 9'd1) < dims.rows);
	assign inr[dmc_pkg::DIR_LEFT]  = (col_q != '0);
	assign inr[dmc_pkg::DIR_RIGHT] = ((9'(col_q) + 9'd1) < dims.cols);

	assign cand_n = 3'($countones(free_q));

	always_comb begin
		case (cand_n)
			3'd2:    cand_k = {1'b0, rnd_q[0]};
			3'd3:    cand_k = dmc_pkg::mod3_8(rnd_q);
			3'd4:    cand_k = rnd_q[1:0];
			default: cand_k = 2'd0;
		endcase
	end

	assign pick    = dmc_pkg::pick_dir(free_q, cand_k);
	assign nb_dir  = (state_q == dmc_pkg::ST_DECIDE) ? pick : probe_q[1:0];
	assign cap_idx = 2'(probe_q - 3'd1);

	always_comb begin
		nb_col = col_q;
		nb_row = row_q;
		case (nb_dir)
			dmc_pkg::DIR_UP:    nb_row = row_q - RW'(1);
			dmc_pkg::DIR_DOWN:  nb_row = row_q + RW'(1);
			dmc_pkg::DIR_LEFT:  nb_col = col_q - CW'(1);
			dmc_pkg::DIR_RIGHT: nb_col = col_q + CW'(1);
			default: ;
		endcase
	end

	assign clr_last  = (clr_q == {AW{1'b1}});
	assign emit_ok   = !m_tvalid_q || m_tready;
	assign accept    = s_tvalid && s_tready;
	assign stk_raddr = SAW'(sp_q - SPW'(1));
	assign done_flag = (phase_q == dmc_pkg::PH_DONE);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			dmc_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					if (s_tuser == dmc_pkg::ACT_BEGIN) begin
						state_d = dmc_pkg::ST_CLEAR;
					end else if (phase_q != dmc_pkg::PH_RUN) begin
						state_d = dmc_pkg::ST_EMIT;
					end else begin
						state_d = dmc_pkg::ST_PROBE;
					end
				end
			end
			dmc_pkg::ST_CLEAR: begin
				if (clr_last) begin
					state_d = dmc_pkg::ST_EMIT;
				end
			end
			dmc_pkg::ST_PROBE: begin
				if (probe_q == 3'd4) begin
					state_d = dmc_pkg::ST_DECIDE;
				end
			end
			dmc_pkg::ST_DECIDE: begin
				if (cand_n == 3'd0 && sp_q != '0) begin
					state_d = dmc_pkg::ST_POP;
				end else begin
					state_d = dmc_pkg::ST_EMIT;
				end
			end
			dmc_pkg::ST_POP: state_d = dmc_pkg::ST_EMIT;
			dmc_pkg::ST_EMIT: begin
				if (emit_ok) begin
					state_d = dmc_pkg::ST_IDLE;
				end
			end
			default: state_d = dmc_pkg::ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		s_tready  = 1'b0;
		vis_we    = 1'b0;
		vis_waddr = {nb_row, nb_col};
		vis_wdata = 1'b1;
		stk_we    = 1'b0;
		case (state_q)
			dmc_pkg::ST_IDLE: s_tready = 1'b1;
			dmc_pkg::ST_CLEAR: begin
				vis_we    = 1'b1;
				vis_waddr = clr_q;
				vis_wdata = (clr_q == '0);
			end
			dmc_pkg::ST_DECIDE: begin
				vis_we = (cand_n != 3'd0);
				stk_we = (cand_n != 3'd0) && (sp_q < SPW'(SDEPTH));
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (vis_we) begin
			vis_mem[vis_waddr] <= vis_wdata;
		end
		vis_rd_q <= vis_mem[{nb_row, nb_col}];
	end

	always_ff @(posedge clk) begin
		if (stk_we) begin
			stk_mem[sp_q[SAW-1:0]] <= {row_q, col_q};
		end
		stk_rd_q <= stk_mem[stk_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= dmc_pkg::ST_IDLE;
			phase_q    <= dmc_pkg::PH_IDLE;
			col_q      <= '0;
			row_q      <= '0;
			sp_q       <= '0;
			probe_q    <= '0;
			clr_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == dmc_pkg::ST_EMIT && emit_ok) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				dmc_pkg::ST_IDLE: begin
					probe_q <= '0;
					clr_q   <= '0;
					if (accept && s_tuser == dmc_pkg::ACT_BEGIN) begin
						phase_q <= dmc_pkg::PH_RUN;
						col_q   <= '0;
						row_q   <= '0;
						sp_q    <= '0;
					end
				end
				dmc_pkg::ST_CLEAR: clr_q <= clr_q + AW'(1);
				dmc_pkg::ST_PROBE: probe_q <= probe_q + 3'd1;
				dmc_pkg::ST_DECIDE: begin
					if (cand_n != 3'd0) begin
						if (sp_q < SPW'(SDEPTH)) begin
							sp_q <= sp_q + SPW'(1);
						end
						col_q <= nb_col;
						row_q <= nb_row;
					end else if (sp_q != '0) begin
						sp_q <= sp_q - SPW'(1);
					end else begin
						col_q   <= '0;
						row_q   <= '0;
						phase_q <= dmc_pkg::PH_DONE;
					end
				end
				dmc_pkg::ST_POP: begin
					col_q <= stk_rd_q[CW-1:0];
					row_q <= stk_rd_q[AW-1:CW];
				end
				default: ;
			endcase
		end
	end

	// result fields
	always_ff @(posedge clk) begin
		case (state_q)
			dmc_pkg::ST_IDLE: begin
				rnd_q   <= s_tdata;
				wcol_q  <= '0;
				wrow_q  <= '0;
				wkind_q <= dmc_pkg::WALL_NONE;
				ev_q    <= (s_tuser == dmc_pkg::ACT_BEGIN) ? dmc_pkg::EV_BEGIN
					: dmc_pkg::EV_IGNORED;
			end
			dmc_pkg::ST_PROBE: begin
				if (probe_q != 3'd0) begin
					free_q[cap_idx] <= inr[cap_idx] & ~vis_rd_q;
				end
			end
			dmc_pkg::ST_DECIDE: begin
				if (cand_n != 3'd0) begin
					ev_q <= dmc_pkg::EV_MOVE;
					case (pick)
						dmc_pkg::DIR_UP: begin
							wcol_q  <= 5'(nb_col);
							wrow_q  <= 5'(nb_row);
							wkind_q <= dmc_pkg::WALL_BOTTOM;
						end
						dmc_pkg::DIR_DOWN: begin
							wcol_q  <= 5'(col_q);
							wrow_q  <= 5'(row_q);
							wkind_q <= dmc_pkg::WALL_BOTTOM;
						end
						dmc_pkg::DIR_LEFT: begin
							wcol_q  <= 5'(nb_col);
							wrow_q  <= 5'(nb_row);
							wkind_q <= dmc_pkg::WALL_RIGHT;
						end
						default: begin
							wcol_q  <= 5'(col_q);
							wrow_q  <= 5'(row_q);
							wkind_q <= dmc_pkg::WALL_RIGHT;
						end
					endcase
				end else if (sp_q != '0) begin
					ev_q <= dmc_pkg::EV_BACK;
				end else begin
					ev_q <= dmc_pkg::EV_FINISH;
				end
			end
			dmc_pkg::ST_EMIT: begin
				if (emit_ok) begin
					m_tdata_q <= {1'b0, done_flag, wkind_q, wrow_q, wcol_q,
						5'(row_q), 5'(col_q)};
					m_tuser_q <= ev_q;
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

`default_nettype wire
